FILE: hdl/ble_pkg.sv
// Package: shared constants, lookup tables and controller/datapath structs for the level estimator.
`timescale 1ns / 1ps
package ble_pkg;

  localparam int AVG_DEPTH    = 6;
  localparam int TABLE_POINTS = 8;

  localparam int MV_W   = 16;
  localparam int CHG_W  = 2;
  localparam int PCT_W  = 7;
  localparam int PTR_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int SUM_W  = MV_W + $clog2(AVG_DEPTH + 1);
  localparam int TIDX_W = $clog2(TABLE_POINTS);
  localparam int K_W    = $clog2(TABLE_POINTS + 1);
  localparam int V10_W  = MV_W + 4;
  // widest gap between neighboring table points fits here
  localparam int DEN_W  = 11;
  localparam int NUM_W  = DEN_W + PCT_W;
  localparam int DIV_W  = NUM_W;

  // sum / AVG_DEPTH as (sum * AVG_RCP) >> RCP_SH, exact for every sum below 2**SUM_W
  localparam int RCP_SH = SUM_W + $clog2(AVG_DEPTH);
  localparam int RCP_W  = SUM_W + 1;
  localparam int PROD_W = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] AVG_RCP = RCP_W'((2**RCP_SH + AVG_DEPTH - 1) / AVG_DEPTH);

  localparam logic [CHG_W-1:0] CHG_IDLE = 2'd0;
  localparam logic [CHG_W-1:0] CHG_ON   = 2'd1;
  localparam logic [CHG_W-1:0] CHG_DONE = 2'd2;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0] PCT_NONE = 7'd0;

  // table voltages in tenths of a millivolt, highest first
  function automatic logic [MV_W-1:0] volt_tenths(input logic [TIDX_W-1:0] k);
    logic [MV_W-1:0] v;
    case (k)
      3'd0:    v = 16'd41422;
      3'd1:    v = 16'd40112;
      3'd2:    v = 16'd39129;
      3'd3:    v = 16'd38310;
      3'd4:    v = 16'd37749;
      3'd5:    v = 16'd37344;
      3'd6:    v = 16'd36884;
      default: v = 16'd36053;
    endcase
    return v;
  endfunction

  function automatic logic [PCT_W-1:0] pct_point(input logic [TIDX_W-1:0] k);
    logic [PCT_W-1:0] p;
    case (k)
      3'd0:    p = 7'd100;
      3'd1:    p = 7'd86;
      3'd2:    p = 7'd72;
      3'd3:    p = 7'd58;
      3'd4:    p = 7'd43;
      3'd5:    p = 7'd29;
      3'd6:    p = 7'd15;
      default: p = 7'd1;
    endcase
    return p;
  endfunction

  typedef struct packed {
    logic load;      // capture the input beat
    logic ring_upd;  // ring write / refill / clear, first voltage
    logic acc_add;   // add one ring entry to the sum
    logic avg_go;    // multiply the sum by the depth reciprocal
    logic avg_take;  // take the scaled product as the average
    logic adjust;    // subtract the charging offset
    logic lookup;    // find the table segment
    logic mul;       // offset into segment times percent step
    logic pct_go;    // start divider on the interpolation
    logic pct_take;  // add the interpolated part
    logic out_load;  // move the result into the output register
  } ble_cmd_t;

  typedef struct packed {
    logic avg_needed;
    logic sum_last;
    logic div_done;
    logic interp;
  } ble_sts_t;

endpackage

FILE: hdl/ble_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ble_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [ble_pkg::DIV_W-1:0] dividend,
  input  logic [ble_pkg::DEN_W-1:0] divisor,
  output logic [ble_pkg::DIV_W-1:0] quotient,
  output logic                     done
);
  import ble_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   trial;

  always_comb begin
    rem_sh = {rem_r, quo_r[DIV_W-1]};
    trial  = rem_sh - {1'b0, den_r};
    if (!trial[DEN_W]) begin
      rem_nxt = trial[DEN_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[DEN_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

FILE: hdl/ble_dp.sv
// Datapath: sample ring, sum, reciprocal average, offset and table interpolation.
`timescale 1ns / 1ps
module ble_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [ble_pkg::MV_W-1:0]  sample_mv,
  input  logic [ble_pkg::CHG_W-1:0] charge_state,
  input  logic [ble_pkg::MV_W-1:0]  adjust_mv,
  input  ble_pkg::ble_cmd_t         cmd,
  output ble_pkg::ble_sts_t         sts,
  output logic [ble_pkg::MV_W-1:0]  voltage_mv,
  output logic [ble_pkg::PCT_W-1:0] percent
);
  import ble_pkg::*;

  logic [MV_W-1:0]  ring_r [AVG_DEPTH];
  logic [PTR_W-1:0] ptr_r;
  logic [PTR_W-1:0] idx_r;

  logic [MV_W-1:0]   sample_r;
  logic [CHG_W-1:0]  chg_r;
  logic [MV_W-1:0]   adj_r;
  logic [SUM_W-1:0]  acc_r;
  logic [PROD_W-1:0] avg_prod_r;
  logic [MV_W-1:0]   volt_r;
  logic [K_W-1:0]    k_r;
  logic [DEN_W-1:0]  diff_r;
  logic [NUM_W-1:0]  num_r;
  logic [PCT_W-1:0]  pct_r;
  logic [MV_W-1:0]   out_volt_r;
  logic [PCT_W-1:0]  out_pct_r;

  logic [V10_W-1:0]  v10;
  logic [K_W-1:0]    k_sel;
  logic [TIDX_W-1:0] k_t;
  logic [V10_W-1:0]  diff_full;
  logic [TIDX_W-1:0] kr_t;
  logic [PCT_W-1:0]  dp_step;
  logic [TIDX_W-1:0] kr_prev;
  logic [MV_W-1:0]   dv_full;
  logic [DIV_W-1:0]  div_dividend;
  logic [DEN_W-1:0]  div_divisor;
  logic [DIV_W-1:0]  div_q;
  logic              div_done;

  ble_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.pct_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .done     (div_done)
  );

  // segment search: first table point at or below the voltage
  always_comb begin
    v10   = V10_W'({volt_r, 3'b000}) + V10_W'({volt_r, 1'b0});
    k_sel = K_W'(TABLE_POINTS);
    for (int i = TABLE_POINTS - 1; i >= 0; i--) begin
      if (v10 >= V10_W'(volt_tenths(TIDX_W'(i)))) k_sel = K_W'(i);
    end
    k_t       = k_sel[TIDX_W-1:0];
    diff_full = v10 - V10_W'(volt_tenths(k_t));
  end

  always_comb begin
    kr_t         = k_r[TIDX_W-1:0];
    kr_prev      = kr_t - 1'b1;
    dp_step      = pct_point(kr_prev) - pct_point(kr_t);
    dv_full      = volt_tenths(kr_prev) - volt_tenths(kr_t);
    div_dividend = num_r;
    div_divisor  = dv_full[DEN_W-1:0];
  end

  // ring state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AVG_DEPTH; i++) ring_r[i] <= '0;
      ptr_r <= '0;
    end else if (cmd.ring_upd) begin
      if (chg_r == CHG_IDLE) begin
        ring_r[0] <= '0;
      end else if (ring_r[0] == '0) begin
        for (int i = 0; i < AVG_DEPTH; i++) ring_r[i] <= sample_r;
        ptr_r <= '0;
      end else begin
        ring_r[ptr_r] <= sample_r;
        ptr_r <= (ptr_r == PTR_W'(AVG_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= sample_mv;
      chg_r    <= charge_state;
      adj_r    <= adjust_mv;
    end
    if (cmd.ring_upd) begin
      volt_r <= sample_r;
      acc_r  <= '0;
      idx_r  <= '0;
    end
    if (cmd.acc_add) begin
      acc_r <= acc_r + SUM_W'(ring_r[idx_r]);
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.avg_go) avg_prod_r <= PROD_W'(acc_r) * PROD_W'(AVG_RCP);
    if (cmd.avg_take) volt_r <= avg_prod_r[RCP_SH +: MV_W];
    if (cmd.adjust && chg_r != CHG_IDLE) begin
      volt_r <= (volt_r > adj_r) ? volt_r - adj_r : '0;
    end
    if (cmd.lookup) begin
      k_r    <= k_sel;
      diff_r <= diff_full[DEN_W-1:0];
      if (chg_r == CHG_DONE || k_sel == '0) pct_r <= PCT_FULL;
      else if (k_sel == K_W'(TABLE_POINTS)) pct_r <= PCT_NONE;
      else pct_r <= pct_point(k_t);
    end
    if (cmd.mul) num_r <= NUM_W'(diff_r) * NUM_W'(dp_step);
    if (cmd.pct_take) pct_r <= pct_r + div_q[PCT_W-1:0];
    if (cmd.out_load) begin
      out_volt_r <= volt_r;
      out_pct_r  <= pct_r;
    end
  end

  always_comb begin
    sts.avg_needed = (chg_r != CHG_IDLE) && (ring_r[0] != '0);
    sts.sum_last   = (idx_r == PTR_W'(AVG_DEPTH - 1));
    sts.div_done   = div_done;
    sts.interp     = (chg_r != CHG_DONE) && (k_r != '0) && (k_r != K_W'(TABLE_POINTS));
  end

  assign voltage_mv = out_volt_r;
  assign percent    = out_pct_r;

endmodule

FILE: hdl/ble_ctrl.sv
// Controller: sequences one item through the datapath and owns both handshakes.
`timescale 1ns / 1ps
module ble_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ble_pkg::ble_sts_t sts,
  output ble_pkg::ble_cmd_t cmd
);
  import ble_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_UPDATE, S_SUM, S_AVG_GO, S_AVG_WAIT, S_ADJUST,
    S_LOOKUP, S_MUL, S_PCT_GO, S_PCT_WAIT, S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.ring_upd = 1'b1;
        state_nxt    = sts.avg_needed ? S_SUM : S_ADJUST;
      end
      S_SUM: begin
        cmd.acc_add = 1'b1;
        if (sts.sum_last) state_nxt = S_AVG_GO;
      end
      S_AVG_GO: begin
        cmd.avg_go = 1'b1;
        state_nxt  = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        cmd.avg_take = 1'b1;
        state_nxt    = S_ADJUST;
      end
      S_ADJUST: begin
        cmd.adjust = 1'b1;
        state_nxt  = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = sts.interp ? S_PCT_GO : S_FINISH;
      end
      S_PCT_GO: begin
        cmd.pct_go = 1'b1;
        state_nxt  = S_PCT_WAIT;
      end
      S_PCT_WAIT: begin
        if (sts.div_done) begin
          cmd.pct_take = 1'b1;
          state_nxt    = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: hdl/battery_level_estimator.sv
// Top level: battery voltage smoothing and charge-level estimate.
// Steps from the accepting edge to out_tvalid: update, adjust, lookup, multiply, finish
// when the ring is refilled or the charger is idle; averaging adds sum and reciprocal
// multiply and take after update; interpolation adds start, bit-serial divide and done.
// One item at a time; the next beat is taken in the cycle after the result loads.
// Reset (synchronous, rst_n low): ring entries and write pointer cleared, no result held.
`timescale 1ns / 1ps
module battery_level_estimator (
  input  logic        clk,
  input  logic        rst_n,
  // input beat
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [15:0] sample_mv, [17:16] charge_state,
                                  // [33:18] adjust_mv, [39:34] zero
  // result beat
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [15:0] voltage_mv, [22:16] percent, [23] zero
);
  import ble_pkg::*;

  ble_cmd_t         cmd;
  ble_sts_t         sts;
  logic [MV_W-1:0]  voltage_mv;
  logic [PCT_W-1:0] percent;

  // The controller walks each beat through update, optional sum and average,
  // offset, segment search and optional interpolation divide.
  ble_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath holds the ring, the divider and the output register; the
  // output register lets a finished beat wait while the next input is taken.
  ble_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_mv    (in_tdata[15:0]),
    .charge_state (in_tdata[17:16]),
    .adjust_mv    (in_tdata[33:18]),
    .cmd          (cmd),
    .sts          (sts),
    .voltage_mv   (voltage_mv),
    .percent      (percent)
  );

  assign out_tdata = {1'b0, percent, voltage_mv};

endmodule

FILE: test/ble_reading_checker.sv
// Checker: predicts each conditioned voltage and charge percentage and compares the result beats.
`timescale 1ns / 1ps
module ble_reading_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,     // [15:0] sample_mv, [17:16] charge_state, [33:18] adjust_mv
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,    // [15:0] voltage_mv, [22:16] percent
  output int          mismatches,
  output int          outstanding
);
  import ble_pkg::*;

  typedef struct packed {
    logic [MV_W-1:0]  volt;
    logic [PCT_W-1:0] pct;
  } reading_t;

  // discharge curve: tenths of a millivolt, highest first, and the matching level
  int unsigned tenths_tbl [TABLE_POINTS] =
    '{41422, 40112, 39129, 38310, 37749, 37344, 36884, 36053};
  int unsigned level_tbl [TABLE_POINTS] = '{100, 86, 72, 58, 43, 29, 15, 1};

  logic [MV_W-1:0] ring [AVG_DEPTH];
  int              ring_ptr;
  reading_t        readings_q [$];
  int              err_cnt;

  function automatic logic [PCT_W-1:0] charge_percent(input logic [MV_W-1:0] mv);
    int unsigned v10;
    int unsigned pt;
    int          k;
    v10 = 32'(mv);
    v10 = v10 * 10;
    k = 0;
    while (k < TABLE_POINTS && v10 < tenths_tbl[k]) k++;
    if (k == TABLE_POINTS) return PCT_NONE;
    if (k == 0) return PCT_FULL;
    pt = level_tbl[k] + ((v10 - tenths_tbl[k]) * (level_tbl[k-1] - level_tbl[k]))
         / (tenths_tbl[k-1] - tenths_tbl[k]);
    return pt[PCT_W-1:0];
  endfunction

  // updates the ring as the block does, then returns the expected result
  function automatic reading_t predict_reading(input logic [MV_W-1:0]  sample,
                                               input logic [CHG_W-1:0] chg,
                                               input logic [MV_W-1:0]  adjust);
    reading_t    r;
    int unsigned volt;
    int unsigned sum;
    volt = 32'(sample);
    if (chg != CHG_IDLE) begin
      if (ring[0] == '0) begin
        // empty ring: refill with this sample, no averaging
        ring_ptr = 0;
        for (int i = 0; i < AVG_DEPTH; i++) ring[i] = sample;
      end else begin
        ring[ring_ptr] = sample;
        ring_ptr = (ring_ptr + 1) % AVG_DEPTH;
        sum = 0;
        for (int i = 0; i < AVG_DEPTH; i++) sum += 32'(ring[i]);
        volt = sum / AVG_DEPTH;
      end
      volt = (volt > 32'(adjust)) ? volt - 32'(adjust) : 0;
    end else begin
      ring[0] = '0;
    end
    r.volt = volt[MV_W-1:0];
    r.pct  = (chg == CHG_DONE) ? PCT_FULL : charge_percent(r.volt);
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    if (!rst_n) begin
      for (int i = 0; i < AVG_DEPTH; i++) ring[i] = '0;
      ring_ptr = 0;
      readings_q.delete();
      err_cnt = 0;
    end else begin
      // results first: a beat accepted on this edge cannot answer one accepted on it
      if (out_tvalid && out_tready) begin
        got.volt = out_tdata[15:0];
        got.pct  = out_tdata[22:16];
        if (readings_q.size() == 0) begin
          if (err_cnt < 10)
            $display("%0t: result beat with no sample pending: voltage %0d percent %0d",
                     $time, got.volt, got.pct);
          err_cnt++;
        end else begin
          want = readings_q.pop_front();
          if (got.volt !== want.volt || got.pct !== want.pct) begin
            if (err_cnt < 10)
              $display("%0t: mismatch: voltage exp %0d got %0d, percent exp %0d got %0d",
                       $time, want.volt, got.volt, want.pct, got.pct);
            err_cnt++;
          end
        end
      end
      if (in_tvalid && in_tready)
        readings_q.push_back(predict_reading(in_tdata[15:0], in_tdata[17:16], in_tdata[33:18]));
    end
    mismatches  <= err_cnt;
    outstanding <= readings_q.size();
  end

endmodule

FILE: test/tb_battery_level_estimator.sv
// Testbench top: stimulus, handshake pressure and verdict for the battery level estimator.
`timescale 1ns / 1ps
module tb_battery_level_estimator;
  import ble_pkg::*;

  // charger code three has no name in the package; the block treats it as charging
  localparam logic [CHG_W-1:0] CHG_RSVD = 2'd3;

  localparam int RAND_PER_PHASE = 280;  // four phases plus the directed set, about 1150 beats
  localparam int TAIL_CYCLES    = 100;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;    // [15:0] sample_mv, [17:16] charge_state, [33:18] adjust_mv
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;   // [15:0] voltage_mv, [22:16] percent
  int          mismatches;
  int          outstanding;

  // idle and stall odds, percent of cycles
  int          src_idle_pct  = 0;
  int          sink_stall_pct = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  battery_level_estimator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  ble_reading_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // result side: one ready decision per falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic logic [39:0] pack_beat(input logic [MV_W-1:0]  sample,
                                            input logic [CHG_W-1:0] chg,
                                            input logic [MV_W-1:0]  adjust);
    return {6'b0, adjust, chg, sample};
  endfunction

  // mostly charging samples on the discharge curve so averages land in the table;
  // idle beats empty the ring so refills keep happening
  function automatic logic [39:0] random_battery_beat();
    logic [MV_W-1:0]  sample;
    logic [CHG_W-1:0] chg;
    logic [MV_W-1:0]  adjust;
    int               r;
    r = $urandom_range(99);
    if (r < 8)       chg = CHG_IDLE;
    else if (r < 15) chg = CHG_DONE;
    else if (r < 22) chg = CHG_RSVD;
    else             chg = CHG_ON;
    r = $urandom_range(99);
    if (r < 85)      sample = MV_W'($urandom_range(4300, 3500));
    else if (r < 95) sample = MV_W'($urandom);
    else             sample = '0;
    r = $urandom_range(99);
    if (r < 70)      adjust = MV_W'($urandom_range(150, 0));
    else if (r < 90) adjust = MV_W'($urandom_range(600, 0));
    else             adjust = MV_W'($urandom);
    return pack_beat(sample, chg, adjust);
  endfunction

  // holds one beat until accepted; idle cycles come before it at random
  task automatic send_beat(input logic [39:0] beat);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= beat;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop sending until every expected result is back
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // table edges, each just at or above a curve point and just below it
  logic [MV_W-1:0] curve_edges [16] = '{4143, 4142, 4012, 4011, 3913, 3912, 3831, 3830,
                                         3775, 3774, 3735, 3734, 3689, 3688, 3606, 3605};

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed set
    send_beat(pack_beat(16'd0,     CHG_IDLE, 16'd0));
    send_beat(pack_beat(16'hffff,  CHG_IDLE, 16'hffff));
    send_beat(pack_beat(16'd0,     CHG_ON,   16'd0));      // zero refill, ring stays empty
    send_beat(pack_beat(16'd4143,  CHG_ON,   16'd0));      // refills again
    send_beat(pack_beat(16'd4142,  CHG_ON,   16'd0));      // first real average
    send_beat(pack_beat(16'd4012,  CHG_RSVD, 16'd5));      // code three counts as charging
    send_beat(pack_beat(16'd3900,  CHG_ON,   16'hffff));   // offset above voltage clamps
    send_beat(pack_beat(16'd3831,  CHG_DONE, 16'd0));      // complete forces full
    send_beat(pack_beat(16'hffff,  CHG_ON,   16'd0));      // largest sample into the sum
    send_beat(pack_beat(16'd3000,  CHG_IDLE, 16'd1234));   // clears the ring head
    // idle beats pass through, so these hit the lookup directly
    foreach (curve_edges[i]) send_beat(pack_beat(curve_edges[i], CHG_IDLE, 16'd0));
    drain_results();

    // random phases: clean, sender gaps, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 49; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 49; end
        default: begin src_idle_pct = 26; sink_stall_pct = 26; end
      endcase
      repeat (RAND_PER_PHASE) send_beat(random_battery_beat());
      drain_results();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_battery_level_estimator: PASS");
    end else begin
      $display("tb_battery_level_estimator: FAIL");
    end
    $finish;
  end

  // timeout guard; a correct run with stalls finishes well before it fires
  initial begin
    #8_000_000;
    $display("tb_battery_level_estimator: FAIL");
    $finish;
  end

endmodule
